// ===== src/dpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared widths, constants and types of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
package dpp_pkg;

	localparam int COORD_BITS = 12;

	localparam int PIX_W    = 12;
	localparam int DEPTH_W  = 16;
	localparam int CENTER_W = 20;
	localparam int INVF_W   = 16;
	localparam int POINT_W  = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	localparam int OFFS_W  = CENTER_W + 1;
	localparam int MAG_W   = CENTER_W;
	localparam int PROD1_W = MAG_W + DEPTH_W;
	localparam int SPLIT_W = PROD1_W / 2;
	localparam int PART_W  = SPLIT_W + INVF_W;
	localparam int PROD_W  = PROD1_W + INVF_W;
	localparam int FRAC_SHIFT = 20;

	localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((33'd1 << COORD_BITS) - 33'd1);

	localparam logic [CENTER_W-1:0] CENTER_X_RESET = CENTER_W'(29122);
	localparam logic [CENTER_W-1:0] CENTER_Y_RESET = CENTER_W'(22031);
	localparam logic [INVF_W-1:0]   INV_FX_RESET   = INVF_W'(814);
	localparam logic [INVF_W-1:0]   INV_FY_RESET   = INVF_W'(814);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 4'd0,
		REG_CENTER_Y = 4'd1,
		REG_INV_FX   = 4'd2,
		REG_INV_FY   = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [INVF_W-1:0]   inv_fx;
		logic [INVF_W-1:0]   inv_fy;
	} cam_cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

// ===== src/dpp_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_cfg
// Camera intrinsics register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module dpp_cfg import dpp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cam_cfg_t              cam
);

	cam_cfg_t cam_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q.center_x <= CENTER_X_RESET;
			cam_q.center_y <= CENTER_Y_RESET;
			cam_q.inv_fx   <= INV_FX_RESET;
			cam_q.inv_fy   <= INV_FY_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTER_X: cam_q.center_x <= wr_data[CENTER_W-1:0];
				REG_CENTER_Y: cam_q.center_y <= wr_data[CENTER_W-1:0];
				REG_INV_FX:   cam_q.inv_fx   <= wr_data[INVF_W-1:0];
				REG_INV_FY:   cam_q.inv_fy   <= wr_data[INVF_W-1:0];
				default: ;
			endcase
		end
	end

	assign cam = cam_q;

endmodule

// ===== src/dpp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_ctrl
// Valid bits and per-stage load enables of the five-stage pipeline.
// ----------------------------------------------------------------------------
module dpp_ctrl import dpp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      depth_nz,
	input  logic      out_ready,
	output logic      in_ready,
	output logic      out_valid,
	output stage_en_t en
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// A stage may load when it is empty or its word moves on in this cycle.
	always_comb begin
		rdy5 = !valid_s5 || out_ready;
		rdy4 = !valid_s4 || rdy5;
		rdy3 = !valid_s3 || rdy4;
		rdy2 = !valid_s2 || rdy3;
		rdy1 = !valid_s1 || rdy2;
		en.s1 = rdy1;
		en.s2 = rdy2;
		en.s3 = rdy3;
		en.s4 = rdy4;
		en.s5 = rdy5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid && depth_nz;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	assign in_ready  = rdy1;
	assign out_valid = valid_s5;

endmodule

// ===== src/dpp_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_axis
// Datapath of one axis: offset from the principal point, two multiplies,
// a floor shift and saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module dpp_axis import dpp_pkg::*; (
	input  logic                clk,
	input  stage_en_t           en,
	input  logic [PIX_W-1:0]    coord,
	input  logic [CENTER_W-1:0] center,
	input  logic [INVF_W-1:0]   inv_focal,
	input  logic [DEPTH_W-1:0]  depth,
	output logic [POINT_W-1:0]  result
);

	logic [OFFS_W-1:0]  offs;
	logic [PIX_W-1:0]   coord_m;
	logic [MAG_W-1:0]   mag_s1;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [DEPTH_W-1:0] depth_s1;
	logic [PROD1_W-1:0] prod1_s2;
	logic [PART_W-1:0]  part_hi_s3, part_lo_s3;
	logic [PROD_W-1:0]  prod_s4;
	logic [POINT_W-1:0] result_s5;
	logic [POINT_W-1:0] q_floor;
	logic [POINT_W:0]   q_up;
	logic [POINT_W-1:0] res_next;

	always_comb begin
		coord_m = coord & COORD_MASK;
		offs = OFFS_W'({coord_m, 8'd0}) - OFFS_W'(center);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			neg_s1   <= offs[OFFS_W-1];
			mag_s1   <= offs[OFFS_W-1] ? MAG_W'(-offs) : offs[MAG_W-1:0];
			depth_s1 <= depth;
		end
		if (en.s2) begin
			neg_s2   <= neg_s1;
			prod1_s2 <= PROD1_W'(mag_s1) * PROD1_W'(depth_s1);
		end
		if (en.s3) begin
			neg_s3     <= neg_s2;
			part_hi_s3 <= PART_W'(prod1_s2[PROD1_W-1:SPLIT_W]) * PART_W'(inv_focal);
			part_lo_s3 <= PART_W'(prod1_s2[SPLIT_W-1:0]) * PART_W'(inv_focal);
		end
		if (en.s4) begin
			neg_s4  <= neg_s3;
			prod_s4 <= (PROD_W'(part_hi_s3) << SPLIT_W) + PROD_W'(part_lo_s3);
		end
		if (en.s5) begin
			result_s5 <= res_next;
		end
	end

	// A negative value rounds its magnitude up so that the shift is a floor.
	always_comb begin
		q_floor = prod_s4[PROD_W-1:FRAC_SHIFT];
		q_up = {1'b0, q_floor} + (POINT_W+1)'(|prod_s4[FRAC_SHIFT-1:0]);
		if (neg_s4) begin
			if (q_up > {2'b01, {(POINT_W-1){1'b0}}}) begin
				res_next = {1'b1, {(POINT_W-1){1'b0}}};
			end else begin
				res_next = -q_up[POINT_W-1:0];
			end
		end else begin
			if (q_floor[POINT_W-1]) begin
				res_next = {1'b0, {(POINT_W-1){1'b1}}};
			end else begin
				res_next = q_floor;
			end
		end
	end

	assign result = result_s5;

endmodule

// ===== src/depth_pixel_to_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Pinhole back-projection of depth pixels into 3-D points.
// ----------------------------------------------------------------------------
// The input channel takes one depth pixel per word: column, row and depth in
// millimeters. A pixel with zero depth is accepted and then dropped. Every
// other pixel leaves on the output channel as one point: x and y in signed
// 1/16 mm, saturated, and z equal to the depth.
// The configuration channel writes the principal point (Q8) and reciprocal
// focal lengths (Q16) by register index; it is always ready. Write it only
// while no pixel is in flight.
// A pixel passes through five register stages: offset, depth multiply,
// focal multiply in two halves, partial-product add, and rounding with
// saturation in the output register. Throughput is one pixel per cycle
// while the receiver is ready. When the receiver stalls, the pipeline
// fills behind the held output word and empty stages still move forward, so
// input stays ready until all five stages hold words.
// Reset clears all valid bits and loads the default intrinsics.
// ----------------------------------------------------------------------------
module depth_pixel_to_point import dpp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel_column,
	input  logic [PIX_W-1:0]      pixel_row,
	input  logic [DEPTH_W-1:0]    depth_mm,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POINT_W-1:0]    point_x,
	output logic [POINT_W-1:0]    point_y,
	output logic [DEPTH_W-1:0]    point_z,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cam_cfg_t  cam;
	stage_en_t en;
	logic [DEPTH_W-1:0] z_s1, z_s2, z_s3, z_s4, z_s5;

	assign cfg_ready = 1'b1;

	dpp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cam      (cam)
	);

	dpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.depth_nz  (depth_mm != '0),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.en        (en)
	);

	dpp_axis u_axis_x (
		.clk       (clk),
		.en        (en),
		.coord     (pixel_column),
		.center    (cam.center_x),
		.inv_focal (cam.inv_fx),
		.depth     (depth_mm),
		.result    (point_x)
	);

	dpp_axis u_axis_y (
		.clk       (clk),
		.en        (en),
		.coord     (pixel_row),
		.center    (cam.center_y),
		.inv_focal (cam.inv_fy),
		.depth     (depth_mm),
		.result    (point_y)
	);

	always_ff @(posedge clk) begin
		if (en.s1) z_s1 <= depth_mm;
		if (en.s2) z_s2 <= z_s1;
		if (en.s3) z_s3 <= z_s2;
		if (en.s4) z_s4 <= z_s3;
		if (en.s5) z_s5 <= z_s4;
	end

	assign point_z = z_s5;

endmodule

// ===== src/dpp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_checker
// Port-level checks of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
module dpp_checker import dpp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [POINT_W-1:0]    point_x,
	input logic [POINT_W-1:0]    point_y,
	input logic [DEPTH_W-1:0]    point_z,
	input logic                  cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(point_z))
		else $error("Output word dropped or changed while stalled.");

	a_z_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> point_z != '0)
		else $error("Point with zero depth delivered.");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("Input blocked while the output is not stalled.");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("Output valid during reset.");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("Configuration channel not ready.");

endmodule

bind depth_pixel_to_point dpp_checker u_dpp_checker (.*);
